// ===== rtl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies; imported by every module in rtl/.
package ole_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // Match encoder groups hit bits by eight.
  localparam int GRP_SZ   = 8;
  localparam int GIDX_W   = $clog2(GRP_SZ);
  localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  // Beat field widths.
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 3;
  localparam int MIDX_W   = 6;
  localparam int ECNT_W   = 7;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_SEARCH    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_NOP = 2'd0,
    CMD_CMP = 2'd1,
    CMD_INS = 2'd2,
    CMD_DEL = 2'd3
  } cmd_t;

  // Broadcast to every cell.
  typedef struct packed {
    cmd_t              cmd;
    logic [VAL_W-1:0]  key;
    logic [IDX_W-1:0]  target;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

// ===== rtl/ole_cell.sv =====
// One list cell: holds an entry and its match flag, shifts with neighbors.
// Depends on ole_pkg.
module ole_cell (
  input  logic                     clk,
  input  ole_pkg::cell_ctrl_t      ctrl,
  input  logic [ole_pkg::IDX_W-1:0] cell_idx,
  input  logic [ole_pkg::VAL_W-1:0] lower_val,
  input  logic [ole_pkg::VAL_W-1:0] upper_val,
  output logic [ole_pkg::VAL_W-1:0] val,
  output logic                     hit
);
  import ole_pkg::*;

  logic in_list;
  assign in_list = {1'b0, cell_idx} < ctrl.count;

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      CMD_CMP: begin
        hit <= in_list && (val == ctrl.key);
      end
      CMD_INS: begin
        if (cell_idx == ctrl.target) begin
          val <= ctrl.key;
        end else if (cell_idx > ctrl.target) begin
          val <= lower_val;
        end
      end
      CMD_DEL: begin
        if (cell_idx >= ctrl.target) begin
          val <= upper_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/ole_prio.sv =====
// First-match encoder: registered per-group stage, then group select.
// Depends on ole_pkg.
module ole_prio (
  input  logic                        clk,
  input  logic [ole_pkg::CAPACITY-1:0] hits,
  output logic                        found,
  output logic [ole_pkg::IDX_W-1:0]    idx
);
  import ole_pkg::*;

  logic [NGRP*GRP_SZ-1:0] hits_pad;
  logic [NGRP-1:0]        gany_next, gany;
  logic [GIDX_W-1:0]      gidx_next [NGRP];
  logic [GIDX_W-1:0]      gidx      [NGRP];

  assign hits_pad = (NGRP*GRP_SZ)'(hits);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gany_next[g] = 1'b0;
      gidx_next[g] = '0;
      for (int j = GRP_SZ - 1; j >= 0; j--) begin
        if (hits_pad[g*GRP_SZ + j]) begin
          gany_next[g] = 1'b1;
          gidx_next[g] = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    gany <= gany_next;
    for (int g = 0; g < NGRP; g++) begin
      gidx[g] <= gidx_next[g];
    end
  end

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (gany[g]) begin
        found = 1'b1;
        idx   = IDX_W'(g * GRP_SZ) | IDX_W'(gidx[g]);
      end
    end
  end

endmodule

// ===== rtl/ordered_list_engine_top.sv =====
// Ordered list engine: a row of CAPACITY value cells with a sequencer.
// An accepted beat passes S_CMP and S_ENC to S_FIN, which registers the result.
// One item at a time: take, compare in cells, encode first match, then apply
// shift and load result once the result slot is free, which frees the input.
// Reset (rst, synchronous): list empty, no result pending; cell contents
// are left as they are and never read before being written.
module ordered_list_engine_top (
  input  logic                      clk,
  input  logic                      rst,
  // s_tdata: operation[2:0], position[8:3], value[40:9], zero pad [47:41]
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ole_pkg::IN_W-1:0]  s_tdata,
  // m_tdata: status[2:0], match_index[8:3], entry_count[15:9]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ole_pkg::OUT_W-1:0] m_tdata
);
  import ole_pkg::*;

  // Sequencer, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ENC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Latched request.
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] key;

  // List length.
  logic [CNT_W-1:0] count, count_next;

  // Cell row.
  cell_ctrl_t        ctrl;
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0] hits;

  logic              found;
  logic [IDX_W-1:0]  found_idx;

  // Result of the item in S_FIN.
  status_t           res_status;
  logic [MIDX_W-1:0] res_idx;
  cmd_t              fin_cmd;
  logic [IDX_W-1:0]  fin_target;
  logic              out_free;
  logic              s_fire;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op  <= s_tdata[OP_W-1:0];
      pos <= s_tdata[OP_W +: POS_W];
      key <= s_tdata[OP_W+POS_W +: VAL_W];
    end
  end

  // Decide the outcome once the first match is known.
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    fin_cmd    = CMD_NOP;
    fin_target = '0;
    count_next = count;
    priority if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_POS) begin
      if (count >= CNT_W'(CAPACITY)) begin
        res_status = ST_FULL;
      end else if (op == OP_INS_FRONT) begin
        fin_cmd    = CMD_INS;
        count_next = count + 1'b1;
      end else if (op == OP_INS_BACK) begin
        fin_cmd    = CMD_INS;
        fin_target = IDX_W'(count);
        count_next = count + 1'b1;
      end else if (CNT_W'(pos) >= count) begin
        res_status = ST_BADPOS;
      end else begin
        fin_cmd    = CMD_INS;
        fin_target = IDX_W'(pos);
        count_next = count + 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      if (count == '0) begin
        res_status = ST_EMPTY;
      end else if (found) begin
        res_idx    = MIDX_W'(found_idx);
        fin_cmd    = CMD_DEL;
        fin_target = found_idx;
        count_next = count - 1'b1;
      end else begin
        res_status = ST_NOTFOUND;
      end
    end else if (op == OP_SEARCH) begin
      if (found) begin
        res_idx = MIDX_W'(found_idx);
      end else begin
        res_status = ST_NOTFOUND;
      end
    end else begin
      // unknown codes: no change, ok status
    end
  end

  // Cell broadcast: compare in S_CMP, shift in S_FIN when result slot frees.
  always_comb begin
    ctrl.key    = key;
    ctrl.count  = count;
    ctrl.target = fin_target;
    ctrl.cmd    = CMD_NOP;
    if (state == S_CMP) begin
      ctrl.cmd = CMD_CMP;
    end else if (state == S_FIN && out_free) begin
      ctrl.cmd = fin_cmd;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_fire) state_next = S_CMP;
      S_CMP:  state_next = S_ENC;
      S_ENC:  state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && out_free) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_tdata <= {ECNT_W'(count_next), res_idx, res_status};
    end
  end

  // Row of cells; each end sees zero beyond the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lower_val, upper_val;
    if (i == 0) begin : g_lo
      assign lower_val = '0;
    end else begin : g_lo
      assign lower_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign upper_val = '0;
    end else begin : g_hi
      assign upper_val = cell_val[i+1];
    end
    ole_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(i)),
      .lower_val (lower_val),
      .upper_val (upper_val),
      .val       (cell_val[i]),
      .hit       (hits[i])
    );
  end

  ole_prio u_prio (
    .clk   (clk),
    .hits  (hits),
    .found (found),
    .idx   (found_idx)
  );

  // Checks.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> state == S_CMP)
    else $error("accepted beat did not start compare");

  a_out_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> m_tvalid && m_tdata[15:9] == ECNT_W'(count))
    else $error("result count disagrees with list count");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free && res_status == ST_FULL) |-> count == CNT_W'(CAPACITY))
    else $error("full reported on a list with room");

endmodule

// ===== test/tb_ordered_list_engine_top.sv =====
// Self-checking bench for ordered_list_engine_top: a directed table, then random ops.
// Expected results come from a shadow list kept in step with accepted input beats.
// Depends on rtl/ole_pkg.sv and rtl/ordered_list_engine_top.sv.
`timescale 1ns / 1ps

module tb_ordered_list_engine_top;
  import ole_pkg::*;

  // Op codes 5..7 are not decoded by the block; it answers them as no-ops.
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_CODE_MAX   = 3'd7;

  localparam int PAD_W       = IN_W - OP_W - POS_W - VAL_W;
  localparam int DIR_N       = 24;
  localparam int RAND_ITEMS  = 800;
  localparam int POOL_N      = 16;
  localparam int MAX_REPORTS = 10;
  // Longest legal quiet stretch is the longest sender gap plus the longest
  // sink stall plus the pipe through the block; this is many times that.
  localparam int WDOG_LIMIT  = 1000;
  // Extra wait after the last expected result, to catch stray result beats.
  localparam int TAIL_CYCLES = 12;

  // Packed MSB first so m_tdata casts straight onto it.
  typedef struct packed {
    logic [ECNT_W-1:0] cnt;
    logic [MIDX_W-1:0] midx;
    logic [STAT_W-1:0] status;
  } op_result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               typed;  // res below is hand-written, else use the shadow list
    op_result_t       res;
  } dir_row_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;

  // Shadow copy of the list, updated when an input beat is taken.
  logic [VAL_W-1:0]      shadow_list [CAPACITY];
  int                    shadow_cnt = 0;
  op_result_t            pending_results [$];

  dir_row_t              dir_tab [DIR_N];
  logic [VAL_W-1:0]      val_pool [POOL_N];

  int                    n_mismatch  = 0;
  int                    idle_cycles = 0;
  int                    stall_left  = 0;
  bit                    quiet       = 1'b0;  // no gaps on either side while set
  op_result_t            mon_got, mon_want;

  ordered_list_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // operation[2:0], position[8:3], value[40:9], pad[47:41]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // status[2:0], match_index[8:3], entry_count[15:9]
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic dir_row_t dir_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                       input logic [VAL_W-1:0] val, input bit typed,
                                       input status_t st, input int mi, input int ec);
    dir_row_t row;
    row.op         = op;
    row.pos        = pos;
    row.val        = val;
    row.typed      = typed;
    row.res.status = st;
    row.res.midx   = MIDX_W'(mi);
    row.res.cnt    = ECNT_W'(ec);
    return row;
  endfunction

  // Applies one op to the shadow list and returns the result the block owes.
  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val, output op_result_t res);
    int      hit;
    int      i;
    status_t st;
    logic [MIDX_W-1:0] mi;
    st = ST_OK;
    mi = '0;
    if (op <= OP_INS_POS) begin
      // Full check wins over the position check.
      if (shadow_cnt >= CAPACITY) begin
        st = ST_FULL;
      end else if (op == OP_INS_POS && int'(pos) >= shadow_cnt) begin
        st = ST_BADPOS;
      end else begin
        hit = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? shadow_cnt : int'(pos);
        for (i = shadow_cnt; i > hit; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[hit] = val;
        shadow_cnt++;
      end
    end else if (op == OP_REMOVE || op == OP_SEARCH) begin
      hit = -1;
      for (i = 0; i < shadow_cnt; i++)
        if (hit < 0 && shadow_list[i] == val) hit = i;
      if (op == OP_REMOVE && shadow_cnt == 0) begin
        st = ST_EMPTY;
      end else if (hit < 0) begin
        st = ST_NOTFOUND;
      end else begin
        mi = MIDX_W'(hit);
        if (op == OP_REMOVE) begin
          for (i = hit; i < shadow_cnt - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_cnt--;
        end
      end
    end
    res.status = st;
    res.midx   = mi;
    res.cnt    = ECNT_W'(shadow_cnt);
  endtask

  // Presents one input beat, holds it until taken, then books its result.
  // tvalid stays high after the beat so back-to-back beats need no extra edge.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input bit typed,
                         input op_result_t typed_res);
    int         gap;
    op_result_t pred;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) >= 55) gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, val, pos, op};
    do @(posedge clk); while (!s_tready);
    apply_list_op(op, pos, val, pred);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Sink: random stalls of the same shape as the sender gaps.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 20) stall_left <= pick_gap();
    end
  end

  // Result checker: every result beat against the oldest booked result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mon_got = op_result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result beat: status %0d idx %0d count %0d",
                   mon_got.status, mon_got.midx, mon_got.cnt);
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got !== mon_want) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("result mismatch: status %0d/%0d idx %0d/%0d count %0d/%0d (exp/got)",
                     mon_want.status, mon_got.status, mon_want.midx, mon_got.midx,
                     mon_want.cnt, mon_got.cnt);
        end
      end
    end
  end

  // Watchdog: too long with no beat on either side means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_ordered_list_engine_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int               k;
    int               r;
    int               full_dwell;
    int               empty_dwell;
    bit               filling;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;

    // Directed rows. Hand-written results only where they are obvious;
    // the rest go through the shadow list.
    dir_tab[0]  = dir_row(OP_SEARCH,    0,  32'h0000_0000, 1, ST_NOTFOUND, 0, 0);
    dir_tab[1]  = dir_row(OP_REMOVE,    0,  32'h0000_0005, 1, ST_EMPTY,    0, 0);
    dir_tab[2]  = dir_row(OP_INS_POS,   0,  32'h0000_0009, 1, ST_BADPOS,   0, 0);
    dir_tab[3]  = dir_row(OP_RSVD_FIRST, 0, 32'h0000_0001, 1, ST_OK,       0, 0);
    // append onto an empty list, then take the only entry away again
    dir_tab[4]  = dir_row(OP_INS_BACK,  0,  32'h7FFF_FFFF, 1, ST_OK,       0, 1);
    dir_tab[5]  = dir_row(OP_REMOVE,    0,  32'h7FFF_FFFF, 1, ST_OK,       0, 0);
    dir_tab[6]  = dir_row(OP_INS_FRONT, 0,  32'h7FFF_FFFF, 1, ST_OK,       0, 1);
    dir_tab[7]  = dir_row(OP_INS_BACK,  0,  32'h8000_0000, 1, ST_OK,       0, 2);
    // position at the last index goes ahead of the old last entry
    dir_tab[8]  = dir_row(OP_INS_POS,   1,  32'hFFFF_FFFF, 1, ST_OK,       0, 3);
    dir_tab[9]  = dir_row(OP_INS_POS,   63, 32'h0000_0001, 1, ST_BADPOS,   0, 3);
    dir_tab[10] = dir_row(OP_INS_POS,   3,  32'h0000_0002, 1, ST_BADPOS,   0, 3);
    dir_tab[11] = dir_row(OP_SEARCH,    0,  32'h8000_0000, 0, ST_OK,       0, 0);
    dir_tab[12] = dir_row(OP_SEARCH,    63, 32'hFFFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[13] = dir_row(OP_INS_FRONT, 0,  32'h0000_0000, 0, ST_OK,       0, 0);
    dir_tab[14] = dir_row(OP_INS_POS,   0,  32'h5555_5555, 0, ST_OK,       0, 0);
    dir_tab[15] = dir_row(OP_INS_BACK,  0,  32'hAAAA_AAAA, 0, ST_OK,       0, 0);
    dir_tab[16] = dir_row(OP_INS_BACK,  0,  32'h7FFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[17] = dir_row(OP_SEARCH,    0,  32'h7FFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[18] = dir_row(OP_RSVD_MID,  63, 32'hFFFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[19] = dir_row(OP_CODE_MAX,  42, 32'h1234_5678, 0, ST_OK,       0, 0);
    // duplicate value: remove takes the first, search then finds the second
    dir_tab[20] = dir_row(OP_REMOVE,    0,  32'h7FFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[21] = dir_row(OP_SEARCH,    0,  32'h7FFF_FFFF, 0, ST_OK,       0, 0);
    dir_tab[22] = dir_row(OP_REMOVE,    21, 32'h1234_5678, 0, ST_OK,       0, 0);
    dir_tab[23] = dir_row(OP_INS_POS,   5,  32'h0000_FFFF, 0, ST_OK,       0, 0);

    // A small pool of values so removes and searches hit; extremes included.
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h8000_0000;
    val_pool[3] = 32'h7FFF_FFFF;
    for (k = 4; k < POOL_N; k++) val_pool[k] = $urandom;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_N; k++)
      send_op(dir_tab[k].op, dir_tab[k].pos, dir_tab[k].val, dir_tab[k].typed, dir_tab[k].res);

    // Random part: alternate fill and drain phases so the list swings from
    // empty to full and back, dwelling a few ops at each end.
    filling     = 1'b1;
    full_dwell  = 0;
    empty_dwell = 0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (filling && shadow_cnt == CAPACITY) full_dwell++;
      if (!filling && shadow_cnt == 0) empty_dwell++;
      if (filling && full_dwell > 6) begin
        filling    = 1'b0;
        full_dwell = 0;
      end else if (!filling && empty_dwell > 4) begin
        filling     = 1'b1;
        empty_dwell = 0;
      end

      r = $urandom_range(0, 99);
      if (filling) begin
        if      (r < 25) op = OP_INS_FRONT;
        else if (r < 50) op = OP_INS_BACK;
        else if (r < 70) op = OP_INS_POS;
        else if (r < 80) op = OP_REMOVE;
        else if (r < 95) op = OP_SEARCH;
        else             op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_CODE_MAX));
      end else begin
        if      (r < 7)  op = OP_INS_FRONT;
        else if (r < 14) op = OP_INS_BACK;
        else if (r < 20) op = OP_INS_POS;
        else if (r < 75) op = OP_REMOVE;
        else if (r < 93) op = OP_SEARCH;
        else             op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_CODE_MAX));
      end

      // Mostly legal positions, some past the end.
      pos = POS_W'($urandom);
      if (op == OP_INS_POS && shadow_cnt > 0 && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(0, shadow_cnt - 1));

      // Lookups mostly aim at a live entry; other values come from the pool
      // or are fully random.
      if ((op == OP_REMOVE || op == OP_SEARCH) && shadow_cnt > 0 &&
          $urandom_range(0, 99) < 60)
        val = shadow_list[$urandom_range(0, shadow_cnt - 1)];
      else if ($urandom_range(0, 99) < 70)
        val = val_pool[$urandom_range(0, POOL_N - 1)];
      else
        val = $urandom;

      send_op(op, pos, val, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb_ordered_list_engine_top: clean");
    end else begin
      $display("tb_ordered_list_engine_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ole_pkg.sv
rtl/ole_cell.sv
rtl/ole_prio.sv
rtl/ordered_list_engine_top.sv
test/tb_ordered_list_engine_top.sv
